FILE: src/tlvrs_pkg.sv
// ----------------------------------------------------------------------------
// tlvrs_pkg: shared types and constants of the TLV record store
// Holds the field widths, the status and mode codes, and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tlvrs_pkg;

    // Defaults for the top-level parameters.
    localparam int PAGE_BYTES_DEF  = 2048;
    localparam int MAX_PAGES_DEF   = 16;

    // Fixed record format.
    localparam int WORD_BYTES      = 8;
    localparam int HEADER_BYTES    = 8;
    localparam int HEADER_WORDS    = HEADER_BYTES / WORD_BYTES;
    localparam int MAX_VALUE_BYTES = 256;
    localparam int MAX_VALUE_WORDS = (MAX_VALUE_BYTES + WORD_BYTES - 1) / WORD_BYTES;
    localparam int VALUE_N_W       = $clog2(MAX_VALUE_WORDS + 1);

    // Field widths.
    localparam int TAG_W      = 16;
    localparam int LEN_W      = 9;
    localparam int WORD_W     = 64;
    localparam int PAGES_W    = 5;
    localparam int HDR_LEN_W  = 16;

    // Largest header-to-header step a stored header can ask for.
    localparam int MAX_JUMP   = HEADER_WORDS + (2 ** HDR_LEN_W + WORD_BYTES - 2) / WORD_BYTES;
    localparam int JUMP_W     = $clog2(MAX_JUMP + 1);

    localparam logic [TAG_W-1:0]   FREE_TAG           = 16'hFFFF;
    localparam logic [PAGES_W-1:0] REGION_PAGES_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_READ   = 1'b1
    } mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    clear_wr;
        logic    capture;
        logic    ins_reset;
        logic    set_pending;
        status_t pending_code;
        logic    scan_start;
        logic    scan_read;
        logic    scan_eval;
        logic    ins_commit;
        logic    write_value;
        logic    ins_close;
        logic    rd_start;
        logic    rd_read;
        logic    rd_load;
        logic    emit;
        status_t emit_code;
    } tlvrs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic    clear_last;
        logic    mode_read;
        logic    first;
        logic    last;
        logic    bad_arg;
        logic    tag_free;
        logic    off_in_range;
        logic    hdr_free;
        logic    hit;
        logic    fits;
        logic    value_zero;
        logic    can_write;
        logic    rd_last;
        logic    out_free;
        status_t pending;
    } tlvrs_stat_t;

endpackage

FILE: src/tlvrs_ram.sv
// ----------------------------------------------------------------------------
// tlvrs_ram: generic single-port RAM
// One write or one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module tlvrs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: src/tlvrs_ctrl.sv
// ----------------------------------------------------------------------------
// tlvrs_ctrl: sequencing state machine of the TLV record store
// Runs the clearing pass, the header walk, the insert and the read-out
// steps by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module tlvrs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tlvrs_pkg::tlvrs_stat_t stat,
    output tlvrs_pkg::tlvrs_cmd_t  cmd
);

    import tlvrs_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_DECIDE   = 11'b000_0000_0100,
        S_SCAN_RD  = 11'b000_0000_1000,
        S_SCAN_EV  = 11'b000_0001_0000,
        S_SCAN_END = 11'b000_0010_0000,
        S_INS_VAL  = 11'b000_0100_0000,
        S_EMIT     = 11'b000_1000_0000,
        S_RD_ISSUE = 11'b001_0000_0000,
        S_RD_LOAD  = 11'b010_0000_0000,
        S_SPARE    = 11'b100_0000_0000
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    status_t emit_code_reg;
    status_t emit_code_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.pending_code = ST_OK;
        cmd.emit_code  = emit_code_reg;
        state_next     = state_reg;
        emit_code_next = emit_code_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.mode_read)
                begin
                    if (stat.tag_free)
                    begin
                        emit_code_next = ST_INVALID;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN_RD;
                    end
                end
                else if (stat.first)
                begin
                    cmd.ins_reset = 1'b1;
                    if (stat.bad_arg)
                    begin
                        cmd.set_pending  = 1'b1;
                        cmd.pending_code = ST_INVALID;
                        state_next       = S_INS_VAL;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN_RD;
                    end
                end
                else
                begin
                    state_next = S_INS_VAL;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.off_in_range)
                begin
                    cmd.scan_read = 1'b1;
                    state_next    = S_SCAN_EV;
                end
                else
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_EV:
            begin
                cmd.scan_eval = 1'b1;
                state_next    = stat.hdr_free ? S_SCAN_END : S_SCAN_RD;
            end
            S_SCAN_END:
            begin
                if (stat.mode_read)
                begin
                    if (!stat.hit)
                    begin
                        emit_code_next = ST_NOT_FOUND;
                        state_next     = S_EMIT;
                    end
                    else if (stat.value_zero)
                    begin
                        emit_code_next = ST_OK;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        cmd.rd_start = 1'b1;
                        state_next   = S_RD_ISSUE;
                    end
                end
                else
                begin
                    if (stat.hit && stat.fits)
                    begin
                        cmd.ins_commit = 1'b1;
                    end
                    else
                    begin
                        cmd.set_pending  = 1'b1;
                        cmd.pending_code = ST_FULL;
                    end
                    state_next = S_INS_VAL;
                end
            end
            S_INS_VAL:
            begin
                cmd.write_value = stat.can_write;
                if (stat.last)
                begin
                    cmd.ins_close  = 1'b1;
                    emit_code_next = stat.pending;
                    state_next     = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD_ISSUE:
            begin
                if (stat.out_free)
                begin
                    cmd.rd_read = 1'b1;
                    state_next  = S_RD_LOAD;
                end
            end
            S_RD_LOAD:
            begin
                cmd.rd_load = 1'b1;
                state_next  = stat.rd_last ? S_IDLE : S_RD_ISSUE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            emit_code_reg <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            emit_code_reg <= emit_code_next;
        end
    end

endmodule

FILE: src/tlvrs_dp.sv
// ----------------------------------------------------------------------------
// tlvrs_dp: datapath of the TLV record store
// Holds the word store, the captured input word, the walk offset and match,
// the append pointer, the pending insert status and the output register.
// ----------------------------------------------------------------------------
module tlvrs_dp #(
    parameter int PAGE_BYTES = tlvrs_pkg::PAGE_BYTES_DEF,
    parameter int MAX_PAGES  = tlvrs_pkg::MAX_PAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [tlvrs_pkg::PAGES_W-1:0] cfg_write_data,
    input  logic                          mode,
    input  logic [tlvrs_pkg::TAG_W-1:0]   tag,
    input  logic [tlvrs_pkg::LEN_W-1:0]   value_length,
    input  logic [tlvrs_pkg::WORD_W-1:0]  value_word,
    input  logic                          word_first,
    input  logic                          word_last,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [1:0]                    status,
    output logic [tlvrs_pkg::LEN_W-1:0]   found_length,
    output logic [tlvrs_pkg::WORD_W-1:0]  read_word,
    output logic                          result_last,
    input  tlvrs_pkg::tlvrs_cmd_t         cmd,
    output tlvrs_pkg::tlvrs_stat_t        stat
);

    import tlvrs_pkg::*;

    localparam int PAGE_WORDS  = PAGE_BYTES / WORD_BYTES;
    localparam int STORE_WORDS = MAX_PAGES * PAGE_WORDS;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int OFF_W       = $clog2(STORE_WORDS + MAX_JUMP);
    localparam int PGS_W       = $clog2(MAX_PAGES + 1);

    // Configuration.
    logic [PAGES_W-1:0] region_pages_reg;
    logic [PGS_W-1:0]   pages_eff;
    logic [OFF_W-1:0]   region_words;

    // Captured input word.
    logic               cap_mode_reg;
    logic [TAG_W-1:0]   cap_tag_reg;
    logic [LEN_W-1:0]   cap_len_reg;
    logic [WORD_W-1:0]  cap_word_reg;
    logic               cap_first_reg;
    logic               cap_last_reg;

    // Header walk.
    logic [OFF_W-1:0]     off_reg;
    logic                 hit_reg;
    logic [ADDR_W-1:0]    hit_at_reg;
    logic [HDR_LEN_W-1:0] hit_len_reg;
    logic [TAG_W-1:0]     scan_tag;
    logic [TAG_W-1:0]     hdr_tag;
    logic [HDR_LEN_W-1:0] hdr_len;
    logic [JUMP_W-1:0]    jump;

    // Insert.
    logic [OFF_W-1:0]     append_ptr_reg;
    logic [VALUE_N_W-1:0] words_left_reg;
    logic                 append_ok_reg;
    status_t              pending_reg;
    logic [VALUE_N_W-1:0] val_words;

    // Read-out.
    logic [LEN_W-1:0]     flen;
    logic [VALUE_N_W-1:0] n_words;
    logic [VALUE_N_W-1:0] k_reg;
    logic [OFF_W-1:0]     rd_idx;
    logic                 beyond_reg;

    // Clearing pass.
    logic [ADDR_W-1:0]    clr_addr_reg;

    // Output register.
    logic                 out_valid_reg;
    status_t              status_reg;
    logic [LEN_W-1:0]     found_length_reg;
    logic [WORD_W-1:0]    read_word_reg;
    logic                 result_last_reg;

    // Store port.
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;

    tlvrs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Out-of-range page counts are pulled into the legal range.
    always_comb
    begin
        if (region_pages_reg == '0)
        begin
            pages_eff = PGS_W'(1);
        end
        else if (32'(region_pages_reg) > MAX_PAGES)
        begin
            pages_eff = PGS_W'(MAX_PAGES);
        end
        else
        begin
            pages_eff = PGS_W'(region_pages_reg);
        end
    end

    assign region_words = OFF_W'(pages_eff) * OFF_W'(PAGE_WORDS);

    assign scan_tag = (cap_mode_reg == MODE_READ) ? cap_tag_reg : FREE_TAG;
    assign hdr_tag  = ram_rdata[TAG_W-1:0];
    assign hdr_len  = ram_rdata[TAG_W+HDR_LEN_W-1:TAG_W];
    assign jump     = JUMP_W'(HEADER_WORDS)
                    + JUMP_W'((17'(hdr_len) + 17'd7) >> 3);

    assign val_words = VALUE_N_W'((10'(cap_len_reg) + 10'd7) >> 3);

    always_comb
    begin
        if (hit_len_reg > HDR_LEN_W'(MAX_VALUE_BYTES))
        begin
            flen = LEN_W'(MAX_VALUE_BYTES);
        end
        else
        begin
            flen = hit_len_reg[LEN_W-1:0];
        end
    end

    assign n_words = VALUE_N_W'((10'(flen) + 10'd7) >> 3);
    assign rd_idx  = OFF_W'(hit_at_reg) + OFF_W'(HEADER_WORDS) + OFF_W'(k_reg);

    // One store access per cycle; the controller never asks for two.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = off_reg[ADDR_W-1:0];
        ram_wdata = cap_word_reg;
        if (cmd.clear_wr)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_addr_reg;
            ram_wdata = '1;
        end
        else if (cmd.ins_commit)
        begin
            ram_we    = 1'b1;
            ram_addr  = hit_at_reg;
            ram_wdata = {{(WORD_W - TAG_W - HDR_LEN_W){1'b0}},
                         HDR_LEN_W'(cap_len_reg), cap_tag_reg};
        end
        else if (cmd.write_value)
        begin
            ram_we    = 1'b1;
            ram_addr  = append_ptr_reg[ADDR_W-1:0];
        end
        else if (cmd.rd_read)
        begin
            ram_addr  = rd_idx[ADDR_W-1:0];
        end
        else if (cmd.scan_read)
        begin
            ram_addr  = off_reg[ADDR_W-1:0];
        end
    end

    always_comb
    begin
        stat.clear_last   = (clr_addr_reg == ADDR_W'(STORE_WORDS - 1));
        stat.mode_read    = (cap_mode_reg == MODE_READ);
        stat.first        = cap_first_reg;
        stat.last         = cap_last_reg;
        stat.bad_arg      = (cap_tag_reg == FREE_TAG)
                         || (32'(cap_len_reg) > MAX_VALUE_BYTES);
        stat.tag_free     = (cap_tag_reg == FREE_TAG);
        stat.off_in_range = (off_reg < region_words);
        stat.hdr_free     = (hdr_tag == FREE_TAG);
        stat.hit          = hit_reg;
        stat.fits         = (OFF_W'(hit_at_reg) + OFF_W'(HEADER_WORDS)
                           + OFF_W'(val_words)) <= region_words;
        stat.value_zero   = (n_words == '0);
        stat.can_write    = append_ok_reg && (words_left_reg != '0)
                         && (append_ptr_reg < OFF_W'(STORE_WORDS));
        stat.rd_last      = ((k_reg + VALUE_N_W'(1)) == n_words);
        stat.out_free     = !out_valid_reg || out_ready;
        stat.pending      = pending_reg;
    end

    // Captured word and walk registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cap_mode_reg  <= mode;
            cap_tag_reg   <= tag;
            cap_len_reg   <= value_length;
            cap_word_reg  <= value_word;
            cap_first_reg <= word_first;
            cap_last_reg  <= word_last;
        end
        if (cmd.scan_start)
        begin
            off_reg <= '0;
            hit_reg <= 1'b0;
        end
        if (cmd.scan_eval)
        begin
            if (hdr_tag == scan_tag)
            begin
                hit_reg     <= 1'b1;
                hit_at_reg  <= off_reg[ADDR_W-1:0];
                hit_len_reg <= hdr_len;
            end
            off_reg <= off_reg + OFF_W'(jump);
        end
        if (cmd.rd_start)
        begin
            k_reg <= '0;
        end
        if (cmd.rd_read)
        begin
            beyond_reg <= (rd_idx >= OFF_W'(STORE_WORDS));
        end
        if (cmd.rd_load)
        begin
            k_reg <= k_reg + VALUE_N_W'(1);
        end
        if (cmd.rd_load)
        begin
            status_reg       <= ST_OK;
            found_length_reg <= flen;
            read_word_reg    <= beyond_reg ? '0 : ram_rdata;
            result_last_reg  <= stat.rd_last;
        end
        else if (cmd.emit)
        begin
            status_reg       <= cmd.emit_code;
            found_length_reg <= '0;
            read_word_reg    <= '0;
            result_last_reg  <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_pages_reg <= REGION_PAGES_RESET;
            clr_addr_reg     <= '0;
            append_ptr_reg   <= '0;
            words_left_reg   <= '0;
            append_ok_reg    <= 1'b0;
            pending_reg      <= ST_INVALID;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                region_pages_reg <= cfg_write_data;
            end
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.ins_reset)
            begin
                append_ok_reg  <= 1'b0;
                words_left_reg <= '0;
            end
            if (cmd.set_pending)
            begin
                pending_reg <= cmd.pending_code;
            end
            if (cmd.ins_commit)
            begin
                append_ptr_reg <= OFF_W'(hit_at_reg) + OFF_W'(HEADER_WORDS);
                words_left_reg <= val_words;
                append_ok_reg  <= 1'b1;
                pending_reg    <= ST_OK;
            end
            if (cmd.write_value)
            begin
                append_ptr_reg <= append_ptr_reg + OFF_W'(1);
            end
            // Closing a run wins over the counter update of its last word.
            if (cmd.ins_close)
            begin
                append_ok_reg  <= 1'b0;
                words_left_reg <= '0;
            end
            else if (cmd.write_value)
            begin
                words_left_reg <= words_left_reg - VALUE_N_W'(1);
            end
            if (cmd.rd_load || cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_length = found_length_reg;
    assign read_word    = read_word_reg;
    assign result_last  = result_last_reg;

endmodule

FILE: src/tlv_log_record_store.sv
// ----------------------------------------------------------------------------
// tlv_log_record_store: append-only tag-length-value record log
// Keeps records as a header word plus value words in a 64-bit word store,
// appends records on insert and streams the latest record of a tag on read.
// ----------------------------------------------------------------------------
// Insert: an accepted word is captured; a word with word_first and a valid
//   argument walks the headers up to the free header or the end of the
//   region and writes the new header if the record fits; the value word is
//   then written, and a word with word_last sends the run's status out.
// Read: the free tag is rejected without a walk; otherwise the headers are
//   walked, and a found record streams its value words one at a time, each
//   waiting for a free output register.
// The single-port store serves one header or value access at a time, and
//   one word is in work at a time; a finished result waits in the output
//   register while the next word is taken.
// Reset: a clearing pass writes all ones to every store word, one per cycle
//   (MAX_PAGES * PAGE_BYTES / 8 words, 4096 by default), with in_ready low.
// ----------------------------------------------------------------------------
module tlv_log_record_store #(
    parameter int PAGE_BYTES = tlvrs_pkg::PAGE_BYTES_DEF,
    parameter int MAX_PAGES  = tlvrs_pkg::MAX_PAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [tlvrs_pkg::PAGES_W-1:0] cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [tlvrs_pkg::TAG_W-1:0]   tag,
    input  logic [tlvrs_pkg::LEN_W-1:0]   value_length,
    input  logic [tlvrs_pkg::WORD_W-1:0]  value_word,
    input  logic                          word_first,
    input  logic                          word_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [tlvrs_pkg::LEN_W-1:0]   found_length,
    output logic [tlvrs_pkg::WORD_W-1:0]  read_word,
    output logic                          result_last
);

    import tlvrs_pkg::*;

    // The controller only sequences; every register that holds record data,
    // offsets or the output word lives in the datapath.
    tlvrs_cmd_t  cmd;
    tlvrs_stat_t stat;

    tlvrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath also owns the word store. The header walk reads each header
    // in a present state, which gives the offset, and an evaluate state, which
    // checks the registered read data and steps to the next header.
    tlvrs_dp #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_PAGES  (MAX_PAGES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .mode           (mode),
        .tag            (tag),
        .value_length   (value_length),
        .value_word     (value_word),
        .word_first     (word_first),
        .word_last      (word_last),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .found_length   (found_length),
        .read_word      (read_word),
        .result_last    (result_last),
        .cmd            (cmd),
        .stat           (stat)
    );

`ifndef SYNTHESIS
    // Each accepted word is worked on alone, so the input closes right after.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // A failed request never carries record data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (found_length == '0 && read_word == '0))
        else $error("failure result carries data");

    // Only value words of a found record come before the final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !result_last) |-> (status == ST_OK && found_length != '0))
        else $error("non-final result that is not a value word");

    // During the clearing pass nothing is accepted and nothing is shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> (!in_ready && !out_valid))
        else $error("activity during the clearing pass");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the TLV record log store
// Drives insert and read words through the valid/ready input, keeps its own
// copy of the record log to predict every result, and compares each result
// word leaving the block, field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    import tlvrs_pkg::*;

    // The predictor's store covers the largest region the block can use.
    localparam int STORE_WORDS  = MAX_PAGES_DEF * PAGE_BYTES_DEF / WORD_BYTES;
    localparam int REPORT_LIMIT = 10;

    // One result word as the block should present it.
    typedef struct packed {
        status_t           code;
        logic [LEN_W-1:0]  length;
        logic [WORD_W-1:0] word;
        logic              last;
    } log_result_t;

    // ------------------------------------------------------------------------
    // The scoreboard keeps a private copy of the record log and the state of
    // the insert run. Every accepted input word is applied to that copy, and
    // the results it should produce are queued in order.
    // ------------------------------------------------------------------------
    class record_log_scoreboard;
        bit [WORD_W-1:0] log_words [STORE_WORDS];
        int unsigned     append_at;
        int unsigned     words_left;
        int unsigned     region_pages;
        bit              append_open;
        status_t         run_status;
        log_result_t     expected_results [$];
        int unsigned     mismatch_count;

        function new();
            foreach (log_words[i]) log_words[i] = '1;
            append_at      = 0;
            words_left     = 0;
            append_open    = 1'b0;
            run_status     = ST_INVALID;
            region_pages   = REGION_PAGES_RESET;
            mismatch_count = 0;
        endfunction

        function void set_region(logic [PAGES_W-1:0] pages);
            region_pages = pages;
        endfunction

        function int unsigned outstanding();
            return expected_results.size();
        endfunction

        // Out-of-range page counts are clamped by the block.
        function int unsigned region_words();
            int unsigned pages;
            pages = region_pages;
            if (pages < 1) pages = 1;
            if (pages > MAX_PAGES_DEF) pages = MAX_PAGES_DEF;
            return pages * PAGE_BYTES_DEF / WORD_BYTES;
        endfunction

        // Walks the headers from the start of the log. The last header that
        // carries the tag wins; the walk ends at the first free header or at
        // the end of the region.
        function bit find_latest(logic [TAG_W-1:0] want_tag, output int unsigned at);
            int unsigned off;
            int unsigned limit;
            int unsigned len;
            bit hit;
            logic [WORD_W-1:0] header;
            off   = 0;
            limit = region_words();
            hit   = 1'b0;
            at    = 0;
            while (off < limit) begin
                header = log_words[off];
                len    = header[31:16];
                if (header[15:0] == want_tag) begin
                    hit = 1'b1;
                    at  = off;
                end
                if (header[15:0] == FREE_TAG) break;
                off += HEADER_WORDS + (len + 7) / 8;
            end
            return hit;
        endfunction

        function void push_result(status_t code, int unsigned len,
                                  logic [WORD_W-1:0] word, bit last);
            log_result_t r;
            r.code   = code;
            r.length = LEN_W'(len);
            r.word   = word;
            r.last   = last;
            expected_results.push_back(r);
        endfunction

        function void note_word(mode_t m, logic [TAG_W-1:0] t, logic [LEN_W-1:0] len,
                                logic [WORD_W-1:0] word, bit first, bit last);
            int unsigned at;
            int unsigned need;
            int unsigned flen;
            int unsigned count;
            int unsigned idx;
            if (m == MODE_INSERT) begin
                // A first word drops any open run and may place a new header.
                if (first) begin
                    append_open = 1'b0;
                    words_left  = 0;
                    if (t == FREE_TAG || len > MAX_VALUE_BYTES) begin
                        run_status = ST_INVALID;
                    end else if (!find_latest(FREE_TAG, at)) begin
                        run_status = ST_FULL;
                    end else begin
                        need = HEADER_WORDS + (len + 7) / 8;
                        if (at + need > region_words()) begin
                            run_status = ST_FULL;
                        end else begin
                            log_words[at] = {32'd0, 7'd0, len, t};
                            append_at     = at + HEADER_WORDS;
                            words_left    = need - HEADER_WORDS;
                            append_open   = 1'b1;
                            run_status    = ST_OK;
                        end
                    end
                end
                // Words past the record's length are dropped.
                if (append_open && words_left > 0 && append_at < STORE_WORDS) begin
                    log_words[append_at] = word;
                    append_at++;
                    words_left--;
                end
                if (last) begin
                    append_open = 1'b0;
                    words_left  = 0;
                    push_result(run_status, 0, '0, 1'b1);
                end
            end else if (t == FREE_TAG) begin
                push_result(ST_INVALID, 0, '0, 1'b1);
            end else if (!find_latest(t, at)) begin
                push_result(ST_NOT_FOUND, 0, '0, 1'b1);
            end else begin
                flen = log_words[at][31:16];
                if (flen > MAX_VALUE_BYTES) flen = MAX_VALUE_BYTES;
                count = (flen + 7) / 8;
                if (count == 0) begin
                    push_result(ST_OK, 0, '0, 1'b1);
                end else begin
                    for (int unsigned k = 0; k < count; k++) begin
                        idx = at + HEADER_WORDS + k;
                        push_result(ST_OK, flen, (idx < STORE_WORDS) ? log_words[idx] : '0,
                                    k + 1 == count);
                    end
                end
            end
        endfunction

        function void check_result(logic [1:0] code, logic [LEN_W-1:0] len,
                                   logic [WORD_W-1:0] word, logic last);
            log_result_t want;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: status %0d length %0d word %h last %b",
                             code, len, word, last);
                return;
            end
            want = expected_results.pop_front();
            if (want.code !== code || want.length !== len || want.word !== word ||
                want.last !== last) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("mismatch: expected status %0d length %0d word %h last %b",
                             want.code, want.length, want.word, want.last);
                    $display("          actual   status %0d length %0d word %h last %b",
                             code, len, word, last);
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write_en;
    logic [PAGES_W-1:0] cfg_write_data;
    logic               in_valid;
    logic               in_ready;
    logic               mode;
    logic [TAG_W-1:0]   tag;
    logic [LEN_W-1:0]   value_length;
    logic [WORD_W-1:0]  value_word;
    logic               word_first;
    logic               word_last;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic [LEN_W-1:0]   found_length;
    logic [WORD_W-1:0]  read_word;
    logic               result_last;

    record_log_scoreboard log_board = new();

    // When set, neither side inserts idle cycles.
    bit               steady;
    int unsigned      words_sent;
    logic [TAG_W-1:0] tag_pool [8];

    always #2 clk = ~clk;

    tlv_log_record_store DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .tag           (tag),
        .value_length  (value_length),
        .value_word    (value_word),
        .word_first    (word_first),
        .word_last     (word_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .found_length  (found_length),
        .read_word     (read_word),
        .result_last   (result_last)
    );

    // Input monitor. The testbench drives with nonblocking assignments, so at
    // the edge every signal read here still holds the value that was present
    // when the word was accepted.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            log_board.note_word(mode_t'(mode), tag, value_length, value_word,
                                word_first, word_last);
    end

    // Output side: check the word taken at this edge, then choose whether to
    // accept on the next one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            log_board.check_result(status, found_length, read_word, result_last);
        out_ready <= steady || ($urandom_range(99) >= 17);
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly tags that already have records, so reads find something.
    function automatic logic [TAG_W-1:0] pick_tag();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5) return FREE_TAG;
        if (roll < 17) return TAG_W'($urandom_range(16'hFFFF));
        return tag_pool[$urandom_range(7)];
    endfunction

    // Short records dominate; a few reach the maximum or exceed it.
    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5) return LEN_W'($urandom_range(511, MAX_VALUE_BYTES + 1));
        if (roll < 9) return LEN_W'(MAX_VALUE_BYTES);
        if (roll < 20) return LEN_W'($urandom_range(MAX_VALUE_BYTES, 41));
        return LEN_W'($urandom_range(40));
    endfunction

    // Presents one word and returns right after the edge that accepts it.
    // Valid stays high from one word to the next unless an idle cycle is drawn.
    task automatic send_word(input mode_t m, input logic [TAG_W-1:0] t,
                             input logic [LEN_W-1:0] len, input logic [WORD_W-1:0] word,
                             input bit first, input bit last);
        while (!steady && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        tag          <= t;
        value_length <= len;
        value_word   <= word;
        word_first   <= first;
        word_last    <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Read requests ignore everything but the tag, so the rest is noise.
    task automatic read_record(input logic [TAG_W-1:0] t);
        send_word(MODE_READ, t, LEN_W'($urandom_range(511)), rand_word(),
                  $urandom_range(1), $urandom_range(1));
        words_sent++;
    endtask

    // Sends one insert run. A positive extra adds words past the record, a
    // negative one leaves the tail erased, and without close the run is left
    // open for the next first word to abandon. Now and then a read slips in
    // between two words of the run.
    task automatic insert_record(input logic [TAG_W-1:0] t, input logic [LEN_W-1:0] len,
                                 input int extra, input bit close);
        int needed;
        int total;
        needed = (len > MAX_VALUE_BYTES) ? 1 : (len + 7) / 8;
        if (needed < 1) needed = 1;
        total = needed + extra;
        if (total < 1) total = 1;
        for (int i = 0; i < total; i++)
        begin
            send_word(MODE_INSERT, (i == 0) ? t : TAG_W'($urandom),
                      (i == 0) ? len : LEN_W'($urandom), rand_word(),
                      i == 0, close && i == total - 1);
            if (i < needed) words_sent++;
            if (i != total - 1 && $urandom_range(99) < 4) read_record(pick_tag());
        end
    endtask

    task automatic random_item();
        int unsigned roll;
        int extra;
        roll = $urandom_range(99);
        if (roll < 55)
        begin
            insert_record(pick_tag(), pick_length(), 0, 1'b1);
        end
        else if (roll < 80)
        begin
            read_record(pick_tag());
        end
        else if (roll < 93)
        begin
            extra = int'($urandom_range(4)) - 2;
            insert_record(pick_tag(), pick_length(), extra, $urandom_range(3) != 0);
        end
        else
        begin
            // A stray word with no first word; it joins an open run if any.
            send_word(MODE_INSERT, TAG_W'($urandom), LEN_W'($urandom), rand_word(),
                      1'b0, $urandom_range(1));
        end
    endtask

    // Holds the sender back until every expected result has been taken, then
    // leaves room for a header walk started by a word that gives no result.
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (log_board.outstanding() != 0);
        repeat (1000) @(negedge clk);
        @(posedge clk);
    endtask

    // Callers, not the block, see that the register only changes while idle.
    task automatic write_region(input logic [PAGES_W-1:0] pages);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= pages;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        log_board.set_region(pages);
    endtask

    initial
    begin
        int unsigned guard;
        steady         = 1'b0;
        words_sent     = 0;
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        in_valid       <= 1'b0;
        mode           <= MODE_INSERT;
        tag            <= '0;
        value_length   <= '0;
        value_word     <= '0;
        word_first     <= 1'b0;
        word_last      <= 1'b0;
        out_ready      <= 1'b0;
        foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom_range(16'hFFFE));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The block erases its store after reset; wait for it to take words.
        do @(negedge clk); while (!in_ready);
        @(posedge clk);

        // Directed part in a one-page region (256 words) so that it fills up.
        write_region(5'd1);

        // Closing a run that never started reports the status left by reset.
        send_word(MODE_INSERT, 16'h1357, 9'd8, '1, 1'b0, 1'b1);
        read_record(FREE_TAG);
        read_record(16'h0000);
        // Zero-length record, then a read of it.
        send_word(MODE_INSERT, 16'h0000, 9'd0, '0, 1'b1, 1'b1);
        read_record(16'h0000);
        // Longest record given a single word: the rest stays erased.
        send_word(MODE_INSERT, 16'hFFFE, 9'd256, '0, 1'b1, 1'b1);
        // Length above the maximum, and the free tag, are both rejected.
        send_word(MODE_INSERT, 16'h1234, 9'd511, '1, 1'b1, 1'b1);
        send_word(MODE_INSERT, FREE_TAG, 9'd8, rand_word(), 1'b1, 1'b1);
        // Two words needed, four sent: the extra ones are dropped.
        insert_record(16'h00A5, 9'd9, 2, 1'b1);
        read_record(16'h00A5);
        read_record(16'hFFFE);
        // A second record with the same tag hides the first one.
        send_word(MODE_INSERT, 16'h0000, 9'd8, rand_word(), 1'b1, 1'b1);
        read_record(16'h0000);
        // A read in the middle of an insert run leaves the run alone.
        send_word(MODE_INSERT, 16'h5A5A, 9'd24, rand_word(), 1'b1, 1'b0);
        read_record(16'h00A5);
        send_word(MODE_INSERT, 16'h5A5A, 9'd24, rand_word(), 1'b0, 1'b0);
        send_word(MODE_INSERT, 16'h5A5A, 9'd24, rand_word(), 1'b0, 1'b1);
        // Fill the region: 43 words are used so far, six full records bring it
        // to 241, the next full one does not fit, one of 15 words fits exactly,
        // and after that no free header is left.
        for (int i = 0; i < 6; i++)
            send_word(MODE_INSERT, tag_pool[i], 9'd256, rand_word(), 1'b1, 1'b1);
        send_word(MODE_INSERT, 16'h4321, 9'd256, rand_word(), 1'b1, 1'b1);
        send_word(MODE_INSERT, 16'h7FFF, 9'd112, rand_word(), 1'b1, 1'b1);
        send_word(MODE_INSERT, 16'h2468, 9'd0, rand_word(), 1'b1, 1'b1);
        read_record(16'h7FFF);
        settle();

        // Largest register value, clamped to the full store, with no idling.
        write_region(5'd31);
        steady = 1'b1;
        while (words_sent < 130) random_item();
        settle();
        steady = 1'b0;

        // A shrunken region: walks now stop well before the records written.
        write_region(5'd2);
        while (words_sent < 180) random_item();
        settle();

        // Zero pages acts as one page.
        write_region(5'd0);
        while (words_sent < 195) random_item();
        settle();

        write_region(5'd16);
        while (words_sent < 270) random_item();
        in_valid <= 1'b0;

        guard = 0;
        while (log_board.outstanding() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (1000) @(negedge clk);

        if (log_board.mismatch_count == 0 && log_board.outstanding() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            if (log_board.outstanding() != 0)
                $display("%0d expected results never arrived", log_board.outstanding());
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: ends a hung run and reports it as failed.
    initial
    begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
